>>> hdl/rc_frame_channel_unpacker_assert.svh
// Assertion macros for the RC frame channel unpacker checker.
// Standalone header; no dependencies.
`ifndef RC_FRAME_CHANNEL_UNPACKER_ASSERT_SVH
`define RC_FRAME_CHANNEL_UNPACKER_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define RCFU_AST_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset.
`define RCFU_AST_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/rcfu_pkg.sv
// Shared constants for the RC frame channel unpacker.
// No dependencies.
package rcfu_pkg;

   localparam int BYTE_W    = 8;
   localparam int CH_IDX_W  = 5;
   localparam int VALUE_W   = 12;

   localparam int RSP_BITS    = CH_IDX_W + VALUE_W;
   localparam int RSP_TDATA_W = ((RSP_BITS + 7) / 8) * 8;

   localparam int FRAME_BYTES_DEF  = 27;
   localparam int NUM_CHANNELS_DEF = 18;

   // header pair, first then second
   localparam logic [BYTE_W-1:0] HDR_FIRST  = 8'h1F;
   localparam logic [BYTE_W-1:0] HDR_SECOND = 8'h38;

endpackage

>>> hdl/rcfu_ram.sv
// Generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
module rcfu_ram #(
   parameter int  WIDTH  = 8,
   parameter int  DEPTH  = 27,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/rcfu_collect.sv
// Header hunt and payload write side of the unpacker.
// Uses rcfu_pkg; writes payload bytes into the frame RAM.
module rcfu_collect #(
   parameter int  FRAME_BYTES = rcfu_pkg::FRAME_BYTES_DEF,
   localparam int ADDR_W      = $clog2(FRAME_BYTES)
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [rcfu_pkg::BYTE_W-1:0] req_tdata,
   output logic                      wr_en,
   output logic [ADDR_W-1:0]         wr_addr,
   output logic [rcfu_pkg::BYTE_W-1:0] wr_data,
   output logic                      start,
   input  logic                      done
);
   import rcfu_pkg::*;

   typedef enum logic [1:0] {
      C_HUNT,
      C_COLLECT,
      C_WAIT
   } state_type;

   localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(FRAME_BYTES - 1);

   state_type         state_ff, state_in;
   logic [ADDR_W-1:0] cnt_ff, cnt_in;
   logic [BYTE_W-1:0] prev_ff, prev_in;
   logic              start_ff, start_in;
   logic              accept;

   assign req_tready = (state_ff != C_WAIT);
   assign accept     = req_tvalid && req_tready;

   // payload byte goes straight to the RAM write port
   assign wr_en   = accept && (state_ff == C_COLLECT);
   assign wr_addr = cnt_ff;
   assign wr_data = req_tdata;
   assign start   = start_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      prev_in  = prev_ff;
      start_in = 1'b0;
      if (accept) begin
         prev_in = req_tdata;
      end
      unique case (state_ff)
         C_HUNT: begin
            if (accept && prev_ff == HDR_FIRST && req_tdata == HDR_SECOND) begin
               state_in = C_COLLECT;
               cnt_in   = '0;
            end
         end
         C_COLLECT: begin
            if (accept) begin
               if (cnt_ff == LAST_POS) begin
                  cnt_in   = '0;
                  start_in = 1'b1;
                  state_in = C_WAIT;
               end else begin
                  cnt_in = cnt_ff + 1'b1;
               end
            end
         end
         C_WAIT: begin
            // store is read back; no writes until the unpack side is done
            if (done) begin
               state_in = C_HUNT;
            end
         end
         default: state_in = C_HUNT;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= C_HUNT;
         cnt_ff   <= '0;
         prev_ff  <= '0;
         start_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         prev_ff  <= prev_in;
         start_ff <= start_in;
      end
   end

endmodule

>>> hdl/rcfu_unpack.sv
// Read-back sequencer: reads three-byte groups from the frame RAM and
// emits two channel values per group (one in the final group of an odd channel count). Uses rcfu_pkg.
module rcfu_unpack #(
   parameter int  FRAME_BYTES  = rcfu_pkg::FRAME_BYTES_DEF,
   parameter int  NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF,
   localparam int ADDR_W       = $clog2(FRAME_BYTES)
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           done,
   output logic                           rd_en,
   output logic [ADDR_W-1:0]              rd_addr,
   input  logic [rcfu_pkg::BYTE_W-1:0]    rd_data,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [rcfu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);
   import rcfu_pkg::*;

   localparam int NUM_GROUPS = (NUM_CHANNELS + 1) / 2;
   localparam int POS_W      = $clog2(3 * NUM_GROUPS + 1);
   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);
   localparam logic [1:0]          LAST_SLOT = 2'd2;

   typedef enum logic [1:0] {
      U_IDLE,
      U_READ,
      U_EMIT_LO,
      U_EMIT_HI
   } state_type;

   state_type           state_ff, state_in;
   logic [POS_W-1:0]    pos_ff, pos_in;
   logic [1:0]          slot_ff, slot_in;
   logic [CH_IDX_W-1:0] ch_ff, ch_in;
   logic                cap_vld_ff, cap_vld_in;
   logic [1:0]          cap_slot_ff, cap_slot_in;
   logic                cap_oob_ff, cap_oob_in;
   logic [BYTE_W-1:0]   grp_ff [3];
   logic [BYTE_W-1:0]   grp_in [3];
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CH_IDX_W-1:0] rsp_idx_ff, rsp_idx_in;
   logic [VALUE_W-1:0]  rsp_value_ff, rsp_value_in;
   logic                rsp_last_ff, rsp_last_in;
   logic                done_ff, done_in;

   logic                in_range;
   logic                out_free;
   logic                is_last;
   logic [VALUE_W-1:0]  lo_value;
   logic [VALUE_W-1:0]  hi_value;

   // positions past the stored frame read as zero
   assign in_range = int'(pos_ff) < FRAME_BYTES;
   assign rd_en    = (state_ff == U_READ) && in_range;
   assign rd_addr  = ADDR_W'(pos_ff);
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign is_last  = (ch_ff == LAST_CH);
   assign lo_value = {grp_ff[1][7:4], grp_ff[0]};
   assign hi_value = {grp_ff[2], grp_ff[1][3:0]};

   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      slot_in      = slot_ff;
      ch_in        = ch_ff;
      cap_vld_in   = 1'b0;
      cap_slot_in  = cap_slot_ff;
      cap_oob_in   = cap_oob_ff;
      grp_in       = grp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_idx_in   = rsp_idx_ff;
      rsp_value_in = rsp_value_ff;
      rsp_last_in  = rsp_last_ff;
      done_in      = 1'b0;

      // read data lands in the cycle after the address
      if (cap_vld_ff) begin
         grp_in[cap_slot_ff] = cap_oob_ff ? '0 : rd_data;
      end

      unique case (state_ff)
         U_IDLE: begin
            if (start) begin
               pos_in   = '0;
               slot_in  = '0;
               ch_in    = '0;
               state_in = U_READ;
            end
         end
         U_READ: begin
            cap_vld_in  = 1'b1;
            cap_slot_in = slot_ff;
            cap_oob_in  = !in_range;
            pos_in      = pos_ff + 1'b1;
            if (slot_ff == LAST_SLOT) begin
               slot_in  = '0;
               state_in = U_EMIT_LO;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
         end
         U_EMIT_LO: begin
            // needs only bytes 0 and 1; byte 2 is captured this cycle
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ch_ff;
               rsp_value_in = lo_value;
               rsp_last_in  = is_last;
               if (is_last) begin
                  done_in  = 1'b1;
                  state_in = U_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = U_EMIT_HI;
               end
            end
         end
         U_EMIT_HI: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_idx_in   = ch_ff;
               rsp_value_in = hi_value;
               rsp_last_in  = is_last;
               if (is_last) begin
                  done_in  = 1'b1;
                  state_in = U_IDLE;
               end else begin
                  ch_in    = ch_ff + 1'b1;
                  state_in = U_READ;
               end
            end
         end
         default: state_in = U_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= U_IDLE;
         cap_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         done_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cap_vld_ff   <= cap_vld_in;
         rsp_valid_ff <= rsp_valid_in;
         done_ff      <= done_in;
      end
      pos_ff       <= pos_in;
      slot_ff      <= slot_in;
      ch_ff        <= ch_in;
      cap_slot_ff  <= cap_slot_in;
      cap_oob_ff   <= cap_oob_in;
      grp_ff       <= grp_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_value_ff <= rsp_value_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign done       = done_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = RSP_TDATA_W'({rsp_value_ff, rsp_idx_ff});

endmodule

>>> hdl/rc_frame_channel_unpacker.sv
// Top level of the RC frame channel unpacker.
// Uses rcfu_pkg, rcfu_collect, rcfu_ram and rcfu_unpack.
//
//  - req channel: one received serial byte per item. While hunting, the pair
//    0x1F then 0x38 opens a frame; the next FRAME_BYTES items are payload,
//    written into the frame RAM one per cycle with no stall.
//  - rsp channel: NUM_CHANNELS items per frame, index 0 upward, twelve-bit
//    values; tlast marks the final channel. Group b0 b1 b2 gives
//    {b1[7:4], b0} then {b2, b1[3:0]}. No checksum check.
//  - Read-back: after the last payload item is accepted, each group is read
//    from the RAM one byte at a time, then its channels are emitted, paced
//    by the single RAM read port; a low rsp_tready stalls the emits.
//  - req_tready is low after the last payload item until the cycle after the
//    final channel is loaded into the output register.
//  - A stalled rsp_tready holds the output register and the read-back
//    sequencer; no result is dropped.
//  - Reset: hunting, previous byte cleared, output empty. The frame RAM is
//    not cleared; every byte read was written first.
module rc_frame_channel_unpacker #(
   parameter int FRAME_BYTES  = rcfu_pkg::FRAME_BYTES_DEF,
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   // req_tdata[7:0]: data_byte
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [rcfu_pkg::BYTE_W-1:0]      req_tdata,
   // rsp_tdata[4:0]: channel_index, [16:5]: channel_value, [23:17]: zero
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [rcfu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   output logic                             rsp_tlast     // last_channel
);
   import rcfu_pkg::*;

   localparam int ADDR_W = $clog2(FRAME_BYTES);

   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [BYTE_W-1:0] wr_data;
   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic [BYTE_W-1:0] rd_data;
   logic              start;
   logic              done;

   // hunt for header, write payload
   rcfu_collect #(
      .FRAME_BYTES (FRAME_BYTES)
   ) u_collect (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .wr_en      (wr_en),
      .wr_addr    (wr_addr),
      .wr_data    (wr_data),
      .start      (start),
      .done       (done)
   );

   // frame store; writer and reader never overlap, collect waits for done
   rcfu_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (FRAME_BYTES)
   ) u_frame_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // read back groups, emit channels
   rcfu_unpack #(
      .FRAME_BYTES  (FRAME_BYTES),
      .NUM_CHANNELS (NUM_CHANNELS)
   ) u_unpack (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .done       (done),
      .rd_en      (rd_en),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

>>> hdl/rcfu_checker.sv
// Port-level checker for the RC frame channel unpacker, bound to the top.
// Uses rcfu_pkg and rc_frame_channel_unpacker_assert.svh.
`include "rc_frame_channel_unpacker_assert.svh"

module rcfu_checker #(
   parameter int NUM_CHANNELS = rcfu_pkg::NUM_CHANNELS_DEF
) (
   input logic                             clock,
   input logic                             reset,
   input logic                             req_tvalid,
   input logic                             req_tready,
   input logic [rcfu_pkg::BYTE_W-1:0]      req_tdata,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [rcfu_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                             rsp_tlast
);
   import rcfu_pkg::*;

   localparam logic [CH_IDX_W-1:0] LAST_CH = CH_IDX_W'(NUM_CHANNELS - 1);

   logic [CH_IDX_W-1:0] rsp_idx;
   logic                rsp_fire;
   logic                req_fire;

   assign rsp_idx  = rsp_tdata[CH_IDX_W-1:0];
   assign rsp_fire = rsp_tvalid && rsp_tready;
   assign req_fire = req_tvalid && req_tready && (req_tdata == req_tdata);

   `RCFU_AST_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast),
      "stalled result changed")

   `RCFU_AST_NOW(a_last_idx, clock, reset, rsp_tvalid,
      rsp_tlast == (rsp_idx == LAST_CH), "tlast not on final channel")

   `RCFU_AST_NEXT(a_idx_step, clock, reset, rsp_fire && !rsp_tlast,
      !rsp_tvalid || (rsp_idx == $past(rsp_idx) + 1'b1), "channel index skipped")

   `RCFU_AST_NEXT(a_idx_wrap, clock, reset, rsp_fire && rsp_tlast && !req_fire,
      !rsp_tvalid || (rsp_idx == '0), "new frame does not start at channel zero")

endmodule

bind rc_frame_channel_unpacker rcfu_checker #(
   .NUM_CHANNELS (NUM_CHANNELS)
) u_rcfu_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);

>>> tb/tb.sv
// Self-checking testbench for rc_frame_channel_unpacker: feeds serial bytes,
// predicts the unpacked channel values and checks every result item in order.
// Depends on rcfu_pkg and the rc_frame_channel_unpacker RTL.
`timescale 1ns / 1ps

module tb;
   import rcfu_pkg::*;

   localparam int FRAME_N    = FRAME_BYTES_DEF;
   localparam int CHAN_N     = NUM_CHANNELS_DEF;
   localparam int CYCLE_CAP  = 200000;
   localparam int LONG_STALL = 250;
   localparam int TAIL_WAIT  = 60;

   // opening bytes: stray second header byte right after reset, a broken pair,
   // a header behind a doubled first byte, then a frame holding both extremes
   // and the header pair as plain data, ending in a first header byte
   localparam int OPEN_N = 34;
   localparam logic [OPEN_N*8-1:0] OPENING = {
      8'h38, 8'h1F, 8'h00, 8'h38, 8'h1F, 8'h1F, 8'h38,
      8'h00, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF,
      8'h1F, 8'h38, 8'h0F, 8'hF0, 8'h0F, 8'h55, 8'hAA, 8'h12, 8'h34,
      8'h56, 8'hAB, 8'hCD, 8'hEF, 8'h01, 8'h80, 8'h7F, 8'hFE, 8'h1F};

   typedef struct {
      logic [CH_IDX_W-1:0] index;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } channel_type;

   typedef struct {
      logic [BYTE_W-1:0] data;
      bit                drain;   // hold this byte back until all channels are in
   } serial_byte_type;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [BYTE_W-1:0]      req_tdata;     // [7:0] data_byte
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;     // [4:0] channel_index, [16:5] channel_value
   logic                   rsp_tlast;     // last_channel

   // predictor state
   bit                hunting_done;       // set while payload is being stored
   int                payload_count;
   logic [BYTE_W-1:0] payload [FRAME_N];
   logic [BYTE_W-1:0] prior_byte;

   serial_byte_type byte_queue[$];
   channel_type     channel_expect[$];
   serial_byte_type next_byte;
   channel_type     want;

   int  errors;
   int  cycles;
   int  channels_seen;
   int  req_gap;
   int  rsp_wait;
   int  rsp_hold;
   bit  req_fire;
   bit  req_calm;
   bit  rsp_calm;

   rc_frame_channel_unpacker uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at cycle %0d: %s", cycles, what);
      errors++;
   endtask

   // bytes past the frame read as zero
   function automatic logic [BYTE_W-1:0] frame_byte(input int pos);
      return (pos < FRAME_N) ? payload[pos] : '0;
   endfunction

   // advance the predictor by one accepted byte
   task automatic decode_byte(input logic [BYTE_W-1:0] b);
      channel_type       ch;
      int                g;
      logic [BYTE_W-1:0] b0;
      logic [BYTE_W-1:0] b1;
      logic [BYTE_W-1:0] b2;
      if (hunting_done) begin
         payload[payload_count] = b;
         payload_count++;
         if (payload_count == FRAME_N) begin
            for (int k = 0; k < CHAN_N; k++) begin
               g  = (k / 2) * 3;
               b0 = frame_byte(g);
               b1 = frame_byte(g + 1);
               b2 = frame_byte(g + 2);
               ch.index = k[CH_IDX_W-1:0];
               if (k % 2 == 0)
                  ch.value = {b1[7:4], b0};
               else
                  ch.value = {b2, b1[3:0]};
               ch.last = (k == CHAN_N - 1);
               channel_expect.push_back(ch);
            end
            hunting_done  = 1'b0;
            payload_count = 0;
         end
      end else if (prior_byte == HDR_FIRST && b == HDR_SECOND) begin
         hunting_done  = 1'b1;
         payload_count = 0;
      end
      prior_byte = b;
   endtask

   function automatic void push_byte(input logic [BYTE_W-1:0] b, input bit drain);
      serial_byte_type s;
      s.data  = b;
      s.drain = drain;
      byte_queue.push_back(s);
   endfunction

   // one frame; chained skips the first header byte (previous frame ended in it),
   // tail_first makes the last payload byte a first header byte
   task automatic add_frame(input bit chained, input bit tail_first, input bit drain_first);
      logic [BYTE_W-1:0] pay [FRAME_N];
      int                p;
      if (!chained)
         push_byte(HDR_FIRST, drain_first);
      push_byte(HDR_SECOND, chained && drain_first);
      for (int i = 0; i < FRAME_N; i++) begin
         pay[i] = BYTE_W'($urandom_range(0, 255));
         if ($urandom_range(0, 15) == 0)
            pay[i] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end
      if ($urandom_range(0, 2) == 0) begin
         p          = $urandom_range(0, FRAME_N - 2);
         pay[p]     = HDR_FIRST;
         pay[p + 1] = HDR_SECOND;
      end
      if (tail_first)
         pay[FRAME_N - 1] = HDR_FIRST;
      for (int i = 0; i < FRAME_N; i++)
         push_byte(pay[i], 1'b0);
   endtask

   // stimulus and end of run
   initial begin
      int                framed;
      int                n;
      bit                chain;
      bit                tail;
      logic [BYTE_W-1:0] b;

      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      rsp_tready = 1'b0;

      for (int i = 0; i < OPEN_N; i++)
         push_byte(OPENING[8 * (OPEN_N - 1 - i) +: 8], 1'b0);
      // header completed by the tail of the frame above
      add_frame(1'b1, 1'b0, 1'b0);

      framed = 0;
      chain  = 1'b0;
      while (framed < 260) begin
         if (chain) begin
            tail = ($urandom_range(0, 3) == 0);
            add_frame(1'b1, tail, 1'b0);
            chain  = tail;
            framed += FRAME_N + 1;
         end else begin
            case ($urandom_range(0, 9))
               7: begin
                  // broken header
                  b = BYTE_W'($urandom_range(0, 255));
                  if (b == HDR_SECOND)
                     b = HDR_FIRST;
                  push_byte(HDR_FIRST, 1'b0);
                  push_byte(b, 1'b0);
               end
               8: push_byte(HDR_SECOND, 1'b0);
               9: begin
                  n = $urandom_range(1, 6);
                  for (int i = 0; i < n; i++)
                     push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
               end
               default: begin
                  n = $urandom_range(0, 3);
                  for (int i = 0; i < n; i++)
                     push_byte(BYTE_W'($urandom_range(0, 255)), 1'b0);
                  tail = ($urandom_range(0, 3) == 0);
                  add_frame(1'b0, tail, framed == 0 || $urandom_range(0, 5) == 0);
                  chain  = tail;
                  framed += FRAME_N + 2;
               end
            endcase
         end
      end

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      while (byte_queue.size() != 0 || req_tvalid)
         @(posedge clock);
      while (channel_expect.size() != 0)
         @(posedge clock);
      repeat (TAIL_WAIT) @(posedge clock);

      if (errors == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

   // sender: offers the queued bytes with random gaps, changes at falling edge
   always @(negedge clock) begin
      if (!reset) begin
         if (!req_tvalid || req_fire) begin
            req_fire = 1'b0;
            if (req_gap > 0) begin
               req_tvalid <= 1'b0;
               req_gap--;
            end else if (byte_queue.size() != 0 &&
                         !(byte_queue[0].drain && channel_expect.size() != 0)) begin
               next_byte = byte_queue.pop_front();
               req_tdata  <= next_byte.data;
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 47) == 0)
                  req_calm = !req_calm;
               req_gap = req_calm ? 0 : $urandom_range(0, 3);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // receiver: random stalls per item, plus a long hold-off when asked
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else if (rsp_wait > 0) begin
         rsp_tready <= 1'b0;
         rsp_wait--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // monitor: handshakes sampled at the rising edge
   always @(posedge clock) begin
      if (!reset) begin
         cycles++;
         if (cycles > CYCLE_CAP) begin
            $display("FAILURE");
            $finish;
         end else begin
            if (req_tvalid && req_tready) begin
               decode_byte(req_tdata);
               req_fire = 1'b1;
            end
            if (rsp_tvalid && rsp_tready) begin
               if (channel_expect.size() == 0) begin
                  report_mismatch("channel item with nothing expected");
               end else begin
                  want = channel_expect.pop_front();
                  if (rsp_tdata[CH_IDX_W-1:0] !== want.index)
                     report_mismatch($sformatf("channel_index %0d, expected %0d",
                                     rsp_tdata[CH_IDX_W-1:0], want.index));
                  if (rsp_tdata[CH_IDX_W +: VALUE_W] !== want.value)
                     report_mismatch($sformatf("channel %0d value 0x%03h, expected 0x%03h",
                                     want.index, rsp_tdata[CH_IDX_W +: VALUE_W], want.value));
                  if (rsp_tlast !== want.last)
                     report_mismatch($sformatf("channel %0d last_channel %b, expected %b",
                                     want.index, rsp_tlast, want.last));
               end
               channels_seen++;
               if ($urandom_range(0, 47) == 0)
                  rsp_calm = !rsp_calm;
               rsp_wait = rsp_calm ? 0 : $urandom_range(0, 3);
               // mid-frame long stalls so the sender backs up behind the block
               if (channels_seen == 50 || channels_seen == 150)
                  rsp_hold = LONG_STALL;
            end
         end
      end
   end

endmodule
